### sv/sstf_disk_request_scheduler_top_macros.svh
// Assertion macros shared by the scheduler's checker.
`ifndef SSTF_DISK_REQUEST_SCHEDULER_TOP_MACROS_SVH
`define SSTF_DISK_REQUEST_SCHEDULER_TOP_MACROS_SVH

// Same-cycle implication, sampled on aclk, off while reset is asserted
`define SSTF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while reset is asserted
`define SSTF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/sstf_pkg.sv
// Package of the SSTF disk request scheduler: sizes, register map, state type.
package sstf_pkg;

    localparam int MAX_BATCH_DEF = 32;
    localparam int RESULT_LIMIT  = 32;

    localparam int CYL_W      = 16;
    localparam int SUM_W      = 21;
    localparam int ACC_W      = SUM_W + 1;
    localparam logic [ACC_W-1:0] SUM_MAX = ACC_W'((1 << SUM_W) - 1);

    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 56;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    // register select is paddr[2]
    localparam logic REG_START_POS = 1'b0;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SCAN,
        ST_PICK
    } state_t;

endpackage

### sv/sstf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sstf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### sv/sstf_disk_request_scheduler_top.sv
// Shortest-seek-time-first disk request scheduler, top level.
//
//  Channel   Direction  Carries
//  s_axis    in         cylinder request, tlast ends the batch
//  m_axis    out        served cylinder, seek distance, running total, tlast on final
//  apb       in/out     start_position register at byte address 0
//
// A request that does not end a batch is stored as it is accepted, while there is room.
// Service of an n-request batch takes n picks: for each, one shared
// distance/compare unit walks the request RAM, one entry per cycle,
// behind the RAM's registered read port; a pick also waits while m_axis stalls.
// s_axis_tready is low from the last request until the final result is loaded.
// Reset is synchronous, active low; the request RAM is not cleared.
module sstf_disk_request_scheduler_top #(
    parameter int MAX_BATCH = sstf_pkg::MAX_BATCH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // slave stream: tdata = cylinder[15:0]; tlast = last
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [sstf_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    input  logic                              s_axis_tlast,
    // master stream: tdata = served_cylinder[15:0], seek_distance[31:16],
    // total_movement[52:32], zero[55:53]; tlast = final_res
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [sstf_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    output logic                              m_axis_tlast,
    // configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [sstf_pkg::APB_AW-1:0]       paddr,
    input  logic [sstf_pkg::APB_DW-1:0]       pwdata,
    output logic [sstf_pkg::APB_DW-1:0]       prdata,
    output logic                              pready
);

    localparam int CYL_W   = sstf_pkg::CYL_W;
    localparam int ACC_W   = sstf_pkg::ACC_W;
    localparam int SUM_W   = sstf_pkg::SUM_W;
    localparam int N_SERVE = (MAX_BATCH < sstf_pkg::RESULT_LIMIT) ?
                             MAX_BATCH : sstf_pkg::RESULT_LIMIT;
    localparam int ADDR_W  = (MAX_BATCH > 1) ? $clog2(MAX_BATCH) : 1;
    localparam int CNT_W   = $clog2(MAX_BATCH + 1);
    localparam int SRV_W   = $clog2(N_SERVE + 1);
    localparam int SIDX_W  = (N_SERVE > 1) ? $clog2(N_SERVE) : 1;
    localparam int PAD_W   = sstf_pkg::OUT_TDATA_W - 2 * CYL_W - SUM_W;

    sstf_pkg::state_t state_reg, state_next;

    logic [CYL_W-1:0]   start_pos_reg, start_pos_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [SRV_W-1:0]   n_reg, n_next;
    logic [SRV_W-1:0]   pick_cnt_reg, pick_cnt_next;
    logic [SRV_W-1:0]   issue_reg, issue_next;
    logic               cmp_vld_reg, cmp_vld_next;
    logic [SIDX_W-1:0]  cmp_idx_reg, cmp_idx_next;
    logic               found_reg, found_next;
    logic [CYL_W-1:0]   best_d_reg, best_d_next;
    logic [CYL_W-1:0]   best_cyl_reg, best_cyl_next;
    logic [SIDX_W-1:0]  best_idx_reg, best_idx_next;
    logic [CYL_W-1:0]   head_reg, head_next;
    logic [ACC_W-1:0]   sum_reg, sum_next;
    logic [N_SERVE-1:0] served_reg, served_next;
    logic               m_valid_reg, m_valid_next;
    logic               m_last_reg, m_last_next;
    logic [sstf_pkg::OUT_TDATA_W-1:0] m_data_reg, m_data_next;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [ADDR_W-1:0] ram_raddr;
    logic [CYL_W-1:0]  ram_rdata;

    logic              in_acc;
    logic              cfg_wr;
    logic              store_room;
    logic [CNT_W-1:0]  count_after;
    logic              issue_done;
    logic [CYL_W-1:0]  seek_dist;
    logic              take;
    logic              out_free;
    logic [SRV_W-1:0]  pick_inc;
    logic              pick_final;
    logic [ACC_W-1:0]  sum_add;
    logic [ACC_W-1:0]  sum_sat;

    // Request store
    sstf_ram #(
        .WIDTH (CYL_W),
        .DEPTH (MAX_BATCH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (s_axis_tdata[CYL_W-1:0]),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Handshakes and shared terms
    assign s_axis_tready = (state_reg == sstf_pkg::ST_LOAD);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign cfg_wr        = psel && penable && pwrite && pready;
    assign store_room    = (count_reg < CNT_W'(MAX_BATCH));
    assign count_after   = store_room ? (count_reg + CNT_W'(1)) : count_reg;
    assign ram_we        = in_acc && store_room;
    assign ram_waddr     = ADDR_W'(count_reg);
    assign ram_raddr     = ADDR_W'(issue_reg);
    assign issue_done    = (issue_reg == n_reg);
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign pick_inc      = pick_cnt_reg + SRV_W'(1);
    assign pick_final    = (pick_inc == n_reg);

    // Shared distance and compare unit
    assign seek_dist = (ram_rdata >= head_reg) ? (ram_rdata - head_reg) :
                                                 (head_reg - ram_rdata);
    assign take = cmp_vld_reg && !served_reg[cmp_idx_reg] &&
                  (!found_reg || (seek_dist < best_d_reg) ||
                   ((seek_dist == best_d_reg) && (ram_rdata < best_cyl_reg)));

    // Saturating running total
    assign sum_add = sum_reg + ACC_W'(best_d_reg);
    assign sum_sat = (sum_add > sstf_pkg::SUM_MAX) ? sstf_pkg::SUM_MAX : sum_add;

    // Configuration register
    assign pready = 1'b1;
    assign prdata = (paddr[2] == sstf_pkg::REG_START_POS) ?
                    sstf_pkg::APB_DW'(start_pos_reg) : '0;
    assign start_pos_next = (cfg_wr && (paddr[2] == sstf_pkg::REG_START_POS)) ?
                            pwdata[CYL_W-1:0] : start_pos_reg;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sstf_pkg::ST_LOAD: begin
                if (in_acc && s_axis_tlast) begin
                    state_next = sstf_pkg::ST_SCAN;
                end
            end
            sstf_pkg::ST_SCAN: begin
                if (issue_done && !cmp_vld_reg) begin
                    state_next = sstf_pkg::ST_PICK;
                end
            end
            sstf_pkg::ST_PICK: begin
                if (out_free) begin
                    state_next = pick_final ? sstf_pkg::ST_LOAD : sstf_pkg::ST_SCAN;
                end
            end
            default: state_next = sstf_pkg::ST_LOAD;
        endcase
    end

    // Datapath and outputs
    always_comb begin
        count_next    = count_reg;
        n_next        = n_reg;
        pick_cnt_next = pick_cnt_reg;
        issue_next    = issue_reg;
        cmp_vld_next  = 1'b0;
        cmp_idx_next  = SIDX_W'(issue_reg);
        found_next    = found_reg;
        best_d_next   = best_d_reg;
        best_cyl_next = best_cyl_reg;
        best_idx_next = best_idx_reg;
        head_next     = head_reg;
        sum_next      = sum_reg;
        served_next   = served_reg;
        m_valid_next  = m_axis_tready ? 1'b0 : m_valid_reg;
        m_last_next   = m_last_reg;
        m_data_next   = m_data_reg;

        // compare stage result, one entry behind the address
        if (take) begin
            found_next    = 1'b1;
            best_d_next   = seek_dist;
            best_cyl_next = ram_rdata;
            best_idx_next = cmp_idx_reg;
        end

        unique case (state_reg)
            sstf_pkg::ST_LOAD: begin
                if (in_acc) begin
                    count_next = count_after;
                    if (s_axis_tlast) begin
                        n_next        = (count_after > CNT_W'(N_SERVE)) ?
                                        SRV_W'(N_SERVE) : SRV_W'(count_after);
                        head_next     = start_pos_reg;
                        sum_next      = '0;
                        pick_cnt_next = '0;
                        issue_next    = '0;
                        found_next    = 1'b0;
                    end
                end
            end
            sstf_pkg::ST_SCAN: begin
                if (!issue_done) begin
                    issue_next   = issue_reg + SRV_W'(1);
                    cmp_vld_next = 1'b1;
                end
            end
            sstf_pkg::ST_PICK: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_last_next   = pick_final;
                    m_data_next   = {PAD_W'(0), sum_sat[SUM_W-1:0], best_d_reg, best_cyl_reg};
                    served_next[best_idx_reg] = 1'b1;
                    head_next     = best_cyl_reg;
                    sum_next      = sum_sat;
                    pick_cnt_next = pick_inc;
                    issue_next    = '0;
                    found_next    = 1'b0;
                    // batch done: drop the stored requests
                    if (pick_final) begin
                        served_next = '0;
                        count_next  = '0;
                        sum_next    = '0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= sstf_pkg::ST_LOAD;
            start_pos_reg <= '0;
            count_reg     <= '0;
            n_reg         <= '0;
            pick_cnt_reg  <= '0;
            issue_reg     <= '0;
            cmp_vld_reg   <= 1'b0;
            found_reg     <= 1'b0;
            head_reg      <= '0;
            sum_reg       <= '0;
            served_reg    <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            start_pos_reg <= start_pos_next;
            count_reg     <= count_next;
            n_reg         <= n_next;
            pick_cnt_reg  <= pick_cnt_next;
            issue_reg     <= issue_next;
            cmp_vld_reg   <= cmp_vld_next;
            found_reg     <= found_next;
            head_reg      <= head_next;
            sum_reg       <= sum_next;
            served_reg    <= served_next;
            m_valid_reg   <= m_valid_next;
        end
        cmp_idx_reg  <= cmp_idx_next;
        best_d_reg   <= best_d_next;
        best_cyl_reg <= best_cyl_next;
        best_idx_reg <= best_idx_next;
        m_last_reg   <= m_last_next;
        m_data_reg   <= m_data_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tlast  = m_last_reg;

endmodule

### sv/sstf_chk.sv
// Port-level checker for the SSTF scheduler, bound to the top level.
`include "sstf_disk_request_scheduler_top_macros.svh"

module sstf_chk (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic                             s_axis_tlast,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [sstf_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                             m_axis_tlast
);

    // the last request of a batch puts the block into service
    `SSTF_ASSERT_NXT(a_busy_after_last, s_axis_tvalid && s_axis_tready && s_axis_tlast, !s_axis_tready, "input still ready after the last request")

    // no new result is started while requests are being taken
    `SSTF_ASSERT_NXT(a_no_result_from_load, s_axis_tready && !m_axis_tvalid, !m_axis_tvalid, "result offered while loading requests")

    // running total never falls below this seek
    `SSTF_ASSERT_IMP(a_total_covers_seek, m_axis_tvalid, m_axis_tdata[31:16] <= m_axis_tdata[52:32], "total movement below seek distance")

    // a stalled result holds
    `SSTF_ASSERT_NXT(a_result_holds, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled result changed")

endmodule

bind sstf_disk_request_scheduler_top sstf_chk u_sstf_chk (.*);

### tb/sstf_service_checker.sv
// Checker for the SSTF scheduler: predicts the service order and compares each result.
module sstf_service_checker
    import sstf_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    // request stream, observed only
    input  logic                    s_axis_tvalid,
    input  logic                    s_axis_tready,
    input  logic [IN_TDATA_W-1:0]   s_axis_tdata,   // cylinder[15:0]
    input  logic                    s_axis_tlast,   // last
    // result stream, observed only
    input  logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    input  logic [OUT_TDATA_W-1:0]  m_axis_tdata,   // cylinder, seek, total, pad
    input  logic                    m_axis_tlast,   // final_res
    // configuration port, observed only
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [APB_AW-1:0]       paddr,
    input  logic [APB_DW-1:0]       pwdata,
    input  logic                    pready,
    // status towards the testbench top
    output int                      mismatch_count,
    output int                      services_due,
    output int                      services_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PAD_W = OUT_TDATA_W - 2 * CYL_W - SUM_W;

    typedef struct packed {
        logic [CYL_W-1:0] cyl;
        logic [CYL_W-1:0] seek;
        logic [SUM_W-1:0] total;
        logic             fin;
    } service_t;

    // Shadow of the block's batch and register
    logic [CYL_W-1:0] req_cyl [MAX_BATCH_DEF];
    int               req_count;
    logic [CYL_W-1:0] head_start;
    service_t         due_q [$];

    // Works out the whole SSTF service order of the held batch
    function automatic void plan_service_order();
        logic             served [MAX_BATCH_DEF];
        logic [CYL_W-1:0] head;
        logic [ACC_W-1:0] sum;
        logic [CYL_W-1:0] gap;
        logic [CYL_W-1:0] best_gap;
        int               best;
        service_t         svc;
        foreach (served[j]) served[j] = 1'b0;
        head = head_start;
        sum  = '0;
        for (int k = 0; k < req_count; k++) begin
            best     = -1;
            best_gap = '0;
            for (int j = 0; j < req_count; j++) begin
                if (!served[j]) begin
                    gap = (req_cyl[j] >= head) ? req_cyl[j] - head : head - req_cyl[j];
                    // nearest wins; a tie goes to the smaller cylinder, then the lower slot
                    if (best < 0 || gap < best_gap ||
                        (gap == best_gap && req_cyl[j] < req_cyl[best])) begin
                        best     = j;
                        best_gap = gap;
                    end
                end
            end
            served[best] = 1'b1;
            head = req_cyl[best];
            sum  = sum + ACC_W'(best_gap);
            if (sum > SUM_MAX)
                sum = SUM_MAX;
            svc.cyl   = head;
            svc.seek  = best_gap;
            svc.total = sum[SUM_W-1:0];
            svc.fin   = (k == req_count - 1);
            due_q.push_back(svc);
        end
        req_count = 0;
    endfunction

    function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            mismatch_count++;
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
        end
    endfunction

    // Sample every transaction at the rising edge
    always @(posedge aclk) begin
        service_t         want;
        logic [CYL_W-1:0] got_cyl;
        logic [CYL_W-1:0] got_seek;
        logic [SUM_W-1:0] got_total;
        logic [PAD_W-1:0] got_pad;
        if (!aresetn) begin
            head_start     = '0;
            req_count      = 0;
            due_q.delete();
            mismatch_count = 0;
            services_seen  = 0;
        end else begin
            // results belong to batches already closed, so check them first
            if (m_axis_tvalid && m_axis_tready) begin
                {got_pad, got_total, got_seek, got_cyl} = m_axis_tdata;
                services_seen++;
                if (due_q.size() == 0) begin
                    mismatch_count++;
                    $display("%0t ns: result with nothing due, expected none, got cylinder %0d",
                             $time, got_cyl);
                end else begin
                    want = due_q.pop_front();
                    check_field("served_cylinder", 32'(want.cyl), 32'(got_cyl));
                    check_field("seek_distance", 32'(want.seek), 32'(got_seek));
                    check_field("total_movement", 32'(want.total), 32'(got_total));
                    check_field("final_res", 32'(want.fin), 32'(m_axis_tlast));
                    check_field("tdata padding", 32'd0, 32'(got_pad));
                end
            end

            // register write; other addresses are ignored by the block
            if (psel && penable && pwrite && pready && paddr[2] == REG_START_POS)
                head_start = pwdata[CYL_W-1:0];

            // request: stored while there is room, last closes the batch
            if (s_axis_tvalid && s_axis_tready) begin
                if (req_count < MAX_BATCH_DEF) begin
                    req_cyl[req_count] = s_axis_tdata[CYL_W-1:0];
                    req_count++;
                end
                if (s_axis_tlast)
                    plan_service_order();
            end
        end
        services_due = due_q.size();
    end

endmodule

### tb/tb.sv
// Testbench top of the SSTF scheduler: clock, reset, stimulus and verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sstf_pkg::*;

    localparam int STALL_PCT     = 21;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 40;
    localparam int IDLE_LIMIT    = 5000;
    localparam int ITEM_TARGET   = 420;
    localparam int HOLD_PHASE    = 4;
    localparam int CALM_PHASE    = 2;
    localparam int OVERFLOW_PHASE = 1;
    localparam int FULL_PHASE    = 3;

    localparam logic [APB_AW-1:0] START_POS_ADDR = {REG_START_POS, 2'b00};
    localparam logic [APB_AW-1:0] UNMAPPED_ADDR  = 3'h4;

    typedef struct {
        logic [CYL_W-1:0] cyl;
        logic             lst;
    } request_t;

    logic                    aclk          = 1'b0;
    logic                    aresetn       = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [IN_TDATA_W-1:0]   s_axis_tdata  = '0;   // cylinder[15:0]
    logic                    s_axis_tlast  = 1'b0; // last
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;         // cylinder, seek, total, pad
    logic                    m_axis_tlast;         // final_res
    logic                    psel          = 1'b0;
    logic                    penable       = 1'b0;
    logic                    pwrite        = 1'b0;
    logic [APB_AW-1:0]       paddr         = '0;
    logic [APB_DW-1:0]       pwdata        = '0;
    logic [APB_DW-1:0]       prdata;
    logic                    pready;

    int mismatch_count;
    int services_due;
    int services_seen;

    request_t request_q [$];
    bit       calm     = 1'b0;
    bit       hold_req = 1'b0;
    int       requests_sent;
    int       batches_sent;
    int       overflow_batches;
    int       start_writes;

    sstf_disk_request_scheduler_top i_dut (.*);

    sstf_service_checker i_checker (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Result side: random back-pressure, one long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= calm || ($urandom_range(99) >= STALL_PCT);
            end
        end
    end

    // Watchdog on cycles without any stream transaction
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("tb: no transaction for %0d cycles, %0d results still due",
                 IDLE_LIMIT, services_due);
        $display("tb: done, errors");
        $finish;
    end

    task automatic write_reg(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_start(input logic [CYL_W-1:0] pos);
        write_reg(START_POS_ADDR, APB_DW'(pos));
        start_writes++;
    endtask

    task automatic add_req(input logic [CYL_W-1:0] cyl, input logic lst);
        request_t req;
        req.cyl = cyl;
        req.lst = lst;
        request_q.push_back(req);
    endtask

    // Mostly small batches, a few full ones and the odd overflowing one
    function automatic int pick_batch_size();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return $urandom_range(1, 6);
        if (r < 88)
            return $urandom_range(7, 20);
        if (r < 95)
            return $urandom_range(21, 31);
        if (r < 98)
            return MAX_BATCH_DEF;
        return $urandom_range(MAX_BATCH_DEF + 1, MAX_BATCH_DEF + 4);
    endfunction

    // Full-range values, values near the head for ties, and the edge cylinders
    function automatic logic [CYL_W-1:0] pick_cylinder(input logic [CYL_W-1:0] near);
        int r;
        int c;
        r = $urandom_range(99);
        if (r < 50)
            return CYL_W'($urandom_range(65535));
        if (r < 80) begin
            c = int'(near) + int'($urandom_range(16)) - 8;
            if (c < 0)
                c = 0;
            if (c > 65535)
                c = 65535;
            return CYL_W'(c);
        end
        case ($urandom_range(3))
            0:       return '0;
            1:       return CYL_W'(1);
            2:       return '1;
            default: return near;
        endcase
    endfunction

    task automatic add_batch(input int size, input logic [CYL_W-1:0] near);
        for (int i = 0; i < size; i++)
            add_req(pick_cylinder(near), i == size - 1);
        if (size > MAX_BATCH_DEF)
            overflow_batches++;
    endtask

    // Offer queued requests with random gaps; valid stays up between back-to-back items
    task automatic send_requests();
        request_t req;
        @(negedge aclk);
        while (request_q.size() != 0) begin
            req = request_q.pop_front();
            while (!calm && $urandom_range(99) < STALL_PCT) begin
                s_axis_tvalid <= 1'b0;
                @(negedge aclk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= req.cyl;
            s_axis_tlast  <= req.lst;
            @(posedge aclk);
            while (!s_axis_tready) @(posedge aclk);
            requests_sent++;
            if (req.lst)
                batches_sent++;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b0;
    endtask

    // Wait for every due result, then let the block settle
    task automatic drain();
        while (services_due != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    initial begin
        int               phase;
        int               r;
        logic [CYL_W-1:0] pos;
        requests_sent    = 0;
        batches_sent     = 0;
        overflow_batches = 0;
        start_writes     = 0;

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset start position: lone requests at both ends of the range
        add_req('0, 1'b1);
        add_req('1, 1'b1);
        send_requests();
        drain();

        // head at the top end; repeated cylinder 1 and both extremes
        set_start('1);
        add_req('0, 1'b0);
        add_req('1, 1'b0);
        add_req(CYL_W'(1), 1'b0);
        add_req(CYL_W'(1), 1'b0);
        add_req(CYL_W'(16'h8000), 1'b1);
        send_requests();
        drain();

        // equal distances either side of the head go to the smaller cylinder
        set_start(CYL_W'(100));
        add_req(CYL_W'(110), 1'b0);
        add_req(CYL_W'(95), 1'b0);
        add_req(CYL_W'(105), 1'b0);
        add_req(CYL_W'(90), 1'b1);
        send_requests();
        drain();

        // write to an unmapped address must leave the start position alone
        set_start(CYL_W'(1));
        write_reg(UNMAPPED_ADDR, 32'h0000_1234);
        add_req(CYL_W'(1), 1'b0);
        add_req(CYL_W'(1), 1'b0);
        add_req('0, 1'b0);
        add_req(CYL_W'(2), 1'b1);
        send_requests();
        drain();

        // random phases, each with its own start position
        phase = 0;
        while (requests_sent < ITEM_TARGET) begin
            r = $urandom_range(99);
            if (r < 15)
                pos = '0;
            else if (r < 30)
                pos = '1;
            else if (r < 40)
                pos = CYL_W'(1);
            else
                pos = CYL_W'($urandom_range(65535));
            set_start(pos);
            calm = (phase == CALM_PHASE);
            if (phase == OVERFLOW_PHASE)
                add_batch(MAX_BATCH_DEF + 4, pos);
            if (phase == FULL_PHASE)
                add_batch(MAX_BATCH_DEF, pos);
            repeat ((phase == HOLD_PHASE) ? 6 : $urandom_range(1, 4))
                add_batch(pick_batch_size(), pos);
            if (phase == HOLD_PHASE)
                hold_req = 1'b1;
            send_requests();
            drain();
            phase++;
        end
        calm = 1'b0;

        $display("tb: %0d requests in %0d batches (%0d overfull), %0d results checked",
                 requests_sent, batches_sent, overflow_batches, services_seen);
        $display("tb: %0d start position settings incl. 0, 1 and 65535, one long output stall",
                 start_writes);
        if (mismatch_count == 0 && services_due == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
